FILE: sv/generational_handle_slot_allocator_macros.svh
// Assertion macros shared by the slot allocator RTL.
`ifndef GENERATIONAL_HANDLE_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_SLOT_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GHSA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GHSA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ghsa_pkg.sv
// Types and fixed field widths for the generational handle slot allocator.
`timescale 1ns / 1ps

package ghsa_pkg;

    localparam int REQ_W  = 2;
    localparam int HIDX_W = 16;
    localparam int HGEN_W = 16;
    localparam int STAT_W = 2;
    localparam int SIDX_W = 8;
    localparam int SGEN_W = 16;
    localparam int RCNT_W = 9;

    typedef enum logic [1:0] {
        REQ_CREATE,
        REQ_DESTROY,
        REQ_CHECK,
        REQ_FLUSH
    } req_t;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_MAKE,
        ST_CHK,
        ST_FLUSH,
        ST_FIN
    } state_t;

endpackage

FILE: sv/generational_handle_slot_allocator.sv
// Top level of the generational handle slot allocator: sequencer and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  s_      | in        | s_valid / s_ready  | req_type, handle_index, handle_generation
//  m_      | out       | m_valid / m_ready  | status, slot_index, slot_generation,
//          |           |                    | recycled_count
//
// Destroy and check read the generation table, and create chains a free-stack read into a
// generation read; each memory read is registered. A create that finds no free slot answers
// without a memory read. Flush pushes back pending-list entries, one entry per cycle.
// After reset a clearing pass over all SLOTS entries loads the free stack and zeroes the
// generation table; s_ready stays low until it ends.
// A finished result waits in the output register while the next item is accepted; a result
// that finds that register still full stalls the sequencer, and a destroy commits its table
// writes only when its result moves.
`timescale 1ns / 1ps
`include "generational_handle_slot_allocator_macros.svh"

module generational_handle_slot_allocator #(
    parameter int SLOTS    = 256,
    parameter int GEN_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ghsa_pkg::REQ_W-1:0]   s_req_type,
    input  logic [ghsa_pkg::HIDX_W-1:0]  s_handle_index,
    input  logic [ghsa_pkg::HGEN_W-1:0]  s_handle_generation,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ghsa_pkg::STAT_W-1:0]  m_status,
    output logic [ghsa_pkg::SIDX_W-1:0]  m_slot_index,
    output logic [ghsa_pkg::SGEN_W-1:0]  m_slot_generation,
    output logic [ghsa_pkg::RCNT_W-1:0]  m_recycled_count
);

    import ghsa_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    // Handle generations are compared zero-extended to the wider of the two widths.
    localparam int CMP_W = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;

    localparam logic [CNT_W-1:0]  SLOTS_C  = CNT_W'(SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [HIDX_W:0]   SLOTS_H  = (HIDX_W + 1)'(SLOTS);

    // Sequencer state.
    state_t state_reg, state_next;

    // Free-stack depth, pending-list depth, clearing pointer.
    logic [CNT_W-1:0] fc_reg, fc_next;
    logic [CNT_W-1:0] pc_reg, pc_next;
    logic [IDX_W-1:0] clr_reg, clr_next;

    // Flush walk: next pending entry to read, pushes left, total to report.
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] rec_reg, rec_next;
    logic [STAT_W-1:0] fin_status_reg, fin_status_next;

    // The item under work.
    req_t              req_reg, req_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [HGEN_W-1:0] hgen_reg, hgen_next;
    logic              in_range_reg, in_range_next;

    // Result register.
    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [SIDX_W-1:0] m_index_reg;
    logic [SGEN_W-1:0] m_gen_reg;
    logic [RCNT_W-1:0] m_count_reg;

    logic              out_free;
    logic              out_load;
    logic [STAT_W-1:0] out_status;
    logic [SIDX_W-1:0] out_index;
    logic [SGEN_W-1:0] out_gen;
    logic [RCNT_W-1:0] out_count;

    // Memory ports: free stack, generation table, pending list.
    logic                fs_we, fs_re;
    logic [IDX_W-1:0]    fs_waddr, fs_raddr, fs_wdata, fs_rdata;
    logic                gt_we, gt_re;
    logic [IDX_W-1:0]    gt_waddr, gt_raddr;
    logic [GEN_BITS-1:0] gt_wdata, gt_rdata;
    logic                pd_we, pd_re;
    logic [IDX_W-1:0]    pd_waddr, pd_raddr, pd_wdata, pd_rdata;

    // Derived values.
    logic [CNT_W-1:0] fc_dec;
    logic [CNT_W-1:0] room;
    logic [CNT_W-1:0] flush_n;
    logic             s_in_range;
    logic             gen_match;
    logic             chk_ok;

    ghsa_ram #(.DEPTH(SLOTS), .WIDTH(IDX_W)) u_free_stack (
        .clk   (aclk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .re    (fs_re),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    ghsa_ram #(.DEPTH(SLOTS), .WIDTH(GEN_BITS)) u_gen_table (
        .clk   (aclk),
        .we    (gt_we),
        .waddr (gt_waddr),
        .wdata (gt_wdata),
        .re    (gt_re),
        .raddr (gt_raddr),
        .rdata (gt_rdata)
    );

    ghsa_ram #(.DEPTH(SLOTS), .WIDTH(IDX_W)) u_pending (
        .clk   (aclk),
        .we    (pd_we),
        .waddr (pd_waddr),
        .wdata (pd_wdata),
        .re    (pd_re),
        .raddr (pd_raddr),
        .rdata (pd_rdata)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign fc_dec     = fc_reg - CNT_W'(1);
    // A flush pushes back only as many slots as the free stack has room for;
    // the later pending entries are dropped.
    assign room       = SLOTS_C - fc_reg;
    assign flush_n    = (pc_reg < room) ? pc_reg : room;
    assign s_in_range = {1'b0, s_handle_index} < SLOTS_H;
    assign gen_match  = CMP_W'(gt_rdata) == CMP_W'(hgen_reg);
    // A destroy also needs room on the pending list.
    assign chk_ok     = in_range_reg && gen_match
                        && ((req_reg == REQ_CHECK) || (pc_reg < SLOTS_C));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            fc_reg    <= SLOTS_C;
            pc_reg    <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            pc_reg    <= pc_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg     <= rd_ptr_next;
        left_reg       <= left_next;
        rec_reg        <= rec_next;
        fin_status_reg <= fin_status_next;
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        hgen_reg       <= hgen_next;
        in_range_reg   <= in_range_next;
    end

    always_comb begin
        state_next      = state_reg;
        fc_next         = fc_reg;
        pc_next         = pc_reg;
        clr_next        = clr_reg;
        rd_ptr_next     = rd_ptr_reg;
        left_next       = left_reg;
        rec_next        = rec_reg;
        fin_status_next = fin_status_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        hgen_next       = hgen_reg;
        in_range_next   = in_range_reg;

        fs_we    = 1'b0;
        fs_waddr = fc_reg[IDX_W-1:0];
        fs_wdata = pd_rdata;
        fs_re    = 1'b0;
        fs_raddr = fc_dec[IDX_W-1:0];
        gt_we    = 1'b0;
        gt_waddr = idx_reg;
        gt_wdata = gt_rdata + GEN_BITS'(1);
        gt_re    = 1'b0;
        gt_raddr = s_handle_index[IDX_W-1:0];
        pd_we    = 1'b0;
        pd_waddr = pc_reg[IDX_W-1:0];
        pd_wdata = idx_reg;
        pd_re    = 1'b0;
        pd_raddr = rd_ptr_reg[IDX_W-1:0];

        out_load   = 1'b0;
        out_status = STAT_OK;
        out_index  = '0;
        out_gen    = '0;
        out_count  = '0;

        case (state_reg)
            ST_CLEAR: begin
                // Stack entry i holds SLOTS-1-i, so slot 0 sits on top.
                fs_we    = 1'b1;
                fs_waddr = clr_reg;
                fs_wdata = LAST_IDX - clr_reg;
                gt_we    = 1'b1;
                gt_waddr = clr_reg;
                gt_wdata = '0;
                if (clr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next      = req_t'(s_req_type);
                    idx_next      = s_handle_index[IDX_W-1:0];
                    hgen_next     = s_handle_generation;
                    in_range_next = s_in_range;
                    case (req_t'(s_req_type))
                        REQ_CREATE: begin
                            if (fc_reg == '0) begin
                                fin_status_next = STAT_FULL;
                                rec_next        = '0;
                                state_next      = ST_FIN;
                            end else begin
                                fs_re      = 1'b1;
                                fc_next    = fc_dec;
                                state_next = ST_POP;
                            end
                        end
                        REQ_DESTROY, REQ_CHECK: begin
                            gt_re      = 1'b1;
                            state_next = ST_CHK;
                        end
                        REQ_FLUSH: begin
                            pc_next         = '0;
                            rec_next        = flush_n;
                            fin_status_next = STAT_OK;
                            if (flush_n == '0) begin
                                state_next = ST_FIN;
                            end else begin
                                pd_re       = 1'b1;
                                pd_raddr    = '0;
                                rd_ptr_next = CNT_W'(1);
                                left_next   = flush_n;
                                state_next  = ST_FLUSH;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP: begin
                gt_re      = 1'b1;
                gt_raddr   = fs_rdata;
                state_next = ST_MAKE;
            end
            ST_MAKE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_index  = SIDX_W'(fs_rdata);
                    out_gen    = SGEN_W'(gt_rdata);
                    state_next = ST_IDLE;
                end
            end
            ST_CHK: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = chk_ok ? STAT_OK : STAT_INVALID;
                    if (chk_ok && (req_reg == REQ_DESTROY)) begin
                        gt_we   = 1'b1;
                        pd_we   = 1'b1;
                        pc_next = pc_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                // Push the entry read last cycle and fetch the next one.
                fs_we     = 1'b1;
                fc_next   = fc_reg + CNT_W'(1);
                left_next = left_reg - CNT_W'(1);
                if (left_reg == CNT_W'(1)) begin
                    state_next = ST_FIN;
                end else begin
                    pd_re       = 1'b1;
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = fin_status_reg;
                    out_count  = RCNT_W'(rec_reg);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= out_status;
            m_index_reg  <= out_index;
            m_gen_reg    <= out_gen;
            m_count_reg  <= out_count;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_slot_index      = m_index_reg;
    assign m_slot_generation = m_gen_reg;
    assign m_recycled_count  = m_count_reg;

    `GHSA_ASSERT_IMP(a_count_bounds, aclk, aresetn, 1'b1,
                     (fc_reg <= SLOTS_C) && (pc_reg <= SLOTS_C), "slot count beyond SLOTS")
    `GHSA_ASSERT_IMP(a_flush_room, aclk, aresetn, state_reg == ST_FLUSH,
                     fc_reg < SLOTS_C, "flush push onto a full free stack")
    `GHSA_ASSERT_IMP(a_clear_quiet, aclk, aresetn, state_reg == ST_CLEAR,
                     !m_valid_reg, "result offered during clearing pass")
    `GHSA_ASSERT_NXT(a_destroy_queue, aclk, aresetn,
                     (state_reg == ST_CHK) && out_free && chk_ok && (req_reg == REQ_DESTROY),
                     pc_reg == $past(pc_reg) + CNT_W'(1), "destroy did not queue its slot")

endmodule

FILE: sv/ghsa_ram.sv
// Simple dual-port synchronous RAM with a registered, holding read port.
`timescale 1ns / 1ps

module ghsa_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read data holds its value on cycles without a read.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
